### design/spq_pkg.sv
`timescale 1ns / 1ps
package spq_pkg;

  localparam int PRIO_W = 16;
  localparam logic signed [PRIO_W-1:0] PRIO_MAX = 16'sh7fff;
  localparam logic signed [PRIO_W-1:0] PRIO_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    OP_ENQ    = 2'd0,
    OP_DEQ    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_CHANGE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef logic signed [PRIO_W-1:0] prio_t;

  // broadcast control to every cell of the row
  typedef struct packed {
    logic  shift_in;
    logic  shift_out;
    logic  add;
    prio_t new_prio;
    prio_t amount;
  } cell_ctl_t;

endpackage

### design/spq_if.sv
`timescale 1ns / 1ps
interface spq_in_if #(parameter int PAYLOAD_BITS = 32);
  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic signed [15:0]       item_priority;
  logic [PAYLOAD_BITS-1:0]  item_payload;
  logic signed [15:0]       change_amount;

  modport source (output valid, op, item_priority, item_payload, change_amount,
                  input ready);
  modport sink (input valid, op, item_priority, item_payload, change_amount,
                output ready);
endinterface

interface spq_out_if #(parameter int PAYLOAD_BITS = 32, parameter int CNT_W = 5);
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [15:0]       out_priority;
  logic [PAYLOAD_BITS-1:0]  out_payload;
  logic [CNT_W-1:0]         entry_count;
  logic                     is_empty;
  logic                     is_full;

  modport source (output valid, status, out_priority, out_payload, entry_count,
                  is_empty, is_full, input ready);
  modport sink (input valid, status, out_priority, out_payload, entry_count,
                is_empty, is_full, output ready);
endinterface

### design/spq_cell.sv
`timescale 1ns / 1ps
module spq_cell #(
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                     clk,
  input  spq_pkg::cell_ctl_t       ctl,
  input  logic                     occ,
  input  logic [PAYLOAD_BITS-1:0]  new_payload,
  input  logic                     left_lt,
  input  spq_pkg::prio_t           left_prio,
  input  logic [PAYLOAD_BITS-1:0]  left_payload,
  input  spq_pkg::prio_t           right_prio,
  input  logic [PAYLOAD_BITS-1:0]  right_payload,
  output spq_pkg::prio_t           prio,
  output logic [PAYLOAD_BITS-1:0]  payload,
  output logic                     lt
);
  import spq_pkg::*;

  prio_t                    prio_r;
  prio_t                    prio_nxt;
  logic [PAYLOAD_BITS-1:0]  payload_r;
  logic [PAYLOAD_BITS-1:0]  payload_nxt;
  logic signed [PRIO_W:0]   sum;
  prio_t                    sat;

  assign lt = occ && (prio_r < ctl.new_prio);

  always_comb begin
    sum = {prio_r[PRIO_W-1], prio_r} + {ctl.amount[PRIO_W-1], ctl.amount};
    priority if (sum > $signed({PRIO_MAX[PRIO_W-1], PRIO_MAX})) begin
      sat = PRIO_MAX;
    end else if (sum < $signed({PRIO_MIN[PRIO_W-1], PRIO_MIN})) begin
      sat = PRIO_MIN;
    end else begin
      sat = sum[PRIO_W-1:0];
    end
  end

  always_comb begin
    prio_nxt    = prio_r;
    payload_nxt = payload_r;
    priority if (ctl.shift_in) begin
      // keep if smaller, take the new word at the boundary, else move right
      priority if (lt) begin
        prio_nxt    = prio_r;
        payload_nxt = payload_r;
      end else if (left_lt) begin
        prio_nxt    = ctl.new_prio;
        payload_nxt = new_payload;
      end else begin
        prio_nxt    = left_prio;
        payload_nxt = left_payload;
      end
    end else if (ctl.shift_out) begin
      prio_nxt    = right_prio;
      payload_nxt = right_payload;
    end else if (ctl.add) begin
      prio_nxt    = sat;
    end
  end

  always_ff @(posedge clk) begin
    prio_r    <= prio_nxt;
    payload_r <= payload_nxt;
  end

  assign prio    = prio_r;
  assign payload = payload_r;

endmodule

### design/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Sorted priority queue built as a row of CAPACITY cells, each holding one entry
// (priority and payload) in ascending priority order. Every operation (enqueue,
// dequeue, peek, change) is done in parallel: all cells compare against the
// new priority, shift, or saturate-add together. A new word is accepted in
// every cycle; its result appears in the output register in the next cycle and
// the input stalls only while that register holds a result not yet taken.
// Nothing needs clearing after reset beyond the entry count and the output valid.
module sorted_priority_queue #(
  parameter int CAPACITY     = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  spq_in_if.sink     in_chan,
  spq_out_if.source  out_chan
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  status_t                  status_r;
  status_t                  status_nxt;
  prio_t                    res_prio_r;
  prio_t                    res_prio_nxt;
  logic [PAYLOAD_BITS-1:0]  res_payload_r;
  logic [PAYLOAD_BITS-1:0]  res_payload_nxt;
  logic [CNT_W-1:0]         res_count_r;

  logic                     in_fire;
  logic                     empty;
  logic                     full;
  op_t                      op;
  cell_ctl_t                ctl;

  prio_t                    prio_w    [CAPACITY];
  logic [PAYLOAD_BITS-1:0]  payload_w [CAPACITY];
  logic                     lt_w      [CAPACITY];

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign op            = op_t'(in_chan.op);
  assign empty         = (count_r == '0);
  assign full          = (count_r == CNT_W'(CAPACITY));

  always_comb begin
    ctl.shift_in    = in_fire && (op == OP_ENQ) && !full;
    ctl.shift_out   = in_fire && (op == OP_DEQ) && !empty;
    ctl.add         = in_fire && (op == OP_CHANGE) && !empty;
    ctl.new_prio    = in_chan.item_priority;
    ctl.amount      = in_chan.change_amount;

    count_nxt       = count_r;
    status_nxt      = ST_OK;
    res_prio_nxt    = '0;
    res_payload_nxt = '0;
    unique case (op)
      OP_ENQ: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          res_prio_nxt    = prio_w[0];
          res_payload_nxt = payload_w[0];
          if (op == OP_DEQ) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      OP_CHANGE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase

    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                     left_lt;
      prio_t                    left_prio;
      logic [PAYLOAD_BITS-1:0]  left_payload;
      prio_t                    right_prio;
      logic [PAYLOAD_BITS-1:0]  right_payload;

      if (gi == 0) begin : g_head
        assign left_lt      = 1'b1;
        assign left_prio    = in_chan.item_priority;
        assign left_payload = in_chan.item_payload;
      end else begin : g_body
        assign left_lt      = lt_w[gi-1];
        assign left_prio    = prio_w[gi-1];
        assign left_payload = payload_w[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_tail
        assign right_prio    = prio_w[gi];
        assign right_payload = payload_w[gi];
      end else begin : g_next
        assign right_prio    = prio_w[gi+1];
        assign right_payload = payload_w[gi+1];
      end

      spq_cell #(
        .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
        .clk           (clk),
        .ctl           (ctl),
        .occ           (count_r > CNT_W'(gi)),
        .new_payload   (in_chan.item_payload),
        .left_lt       (left_lt),
        .left_prio     (left_prio),
        .left_payload  (left_payload),
        .right_prio    (right_prio),
        .right_payload (right_payload),
        .prio          (prio_w[gi]),
        .payload       (payload_w[gi]),
        .lt            (lt_w[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r <= count_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r      <= status_nxt;
      res_prio_r    <= res_prio_nxt;
      res_payload_r <= res_payload_nxt;
      res_count_r   <= count_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = status_r;
  assign out_chan.out_priority = res_prio_r;
  assign out_chan.out_payload  = res_payload_r;
  assign out_chan.entry_count  = res_count_r;
  assign out_chan.is_empty     = (res_count_r == '0);
  assign out_chan.is_full      = (res_count_r == CNT_W'(CAPACITY));

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && op == OP_ENQ && !full) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("enqueue did not add an entry");

  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted word produced no result");

  a_front_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> (prio_w[0] <= prio_w[1]))
    else $error("front entries out of order");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import spq_pkg::*;

  localparam int CAPACITY   = 16;
  localparam int PAY_W      = 32;
  localparam int CNT_W      = 5;
  localparam int IDLE_PCT   = 29;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    status_t           status;
    prio_t             prio;
    logic [PAY_W-1:0]  payload;
    logic [CNT_W-1:0]  count;
    logic              empty;
    logic              full;
  } spq_result_t;

  logic clk;
  logic rst_n;
  logic idling;
  int   fail_count = 0;
  int   stall_cycles = 0;

  // predicted queue contents, front first
  prio_t            queue_prio[$];
  logic [PAY_W-1:0] queue_payload[$];
  spq_result_t      awaited_results[$];

  spq_in_if  #(.PAYLOAD_BITS(PAY_W)) in_chan ();
  spq_out_if #(.PAYLOAD_BITS(PAY_W), .CNT_W(CNT_W)) out_chan ();

  sorted_priority_queue #(
    .CAPACITY(CAPACITY),
    .PAYLOAD_BITS(PAY_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan.sink),
    .out_chan(out_chan.source)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic spq_result_t apply_queue_op(op_t op, prio_t p, logic [PAY_W-1:0] d,
                                                 prio_t amt);
    spq_result_t r;
    int pos;
    int s;
    r.status  = ST_OK;
    r.prio    = '0;
    r.payload = '0;
    case (op)
      OP_ENQ: begin
        if (queue_prio.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < queue_prio.size() && queue_prio[pos] < p) pos++;
          queue_prio.insert(pos, p);
          queue_payload.insert(pos, d);
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (queue_prio.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.prio    = queue_prio[0];
          r.payload = queue_payload[0];
          if (op == OP_DEQ) begin
            void'(queue_prio.pop_front());
            void'(queue_payload.pop_front());
          end
        end
      end
      default: begin
        if (queue_prio.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          foreach (queue_prio[i]) begin
            s = int'(queue_prio[i]) + int'(amt);
            if (s > int'(PRIO_MAX)) s = int'(PRIO_MAX);
            if (s < int'(PRIO_MIN)) s = int'(PRIO_MIN);
            queue_prio[i] = prio_t'(s);
          end
        end
      end
    endcase
    r.count = CNT_W'(queue_prio.size());
    r.empty = (queue_prio.size() == 0);
    r.full  = (queue_prio.size() == CAPACITY);
    return r;
  endfunction

  task automatic send_word(op_t op, prio_t p, logic [PAY_W-1:0] d, prio_t amt);
    int gap;
    if (idling && $urandom_range(99) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.op            <= op;
    in_chan.item_priority <= p;
    in_chan.item_payload  <= d;
    in_chan.change_amount <= amt;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    awaited_results.push_back(apply_queue_op(op, p, d, amt));
    @(negedge clk);
  endtask

  function automatic prio_t pick_prio();
    case ($urandom_range(9))
      0: return PRIO_MAX;
      1: return PRIO_MIN;
      2, 3: return prio_t'($urandom);
      default: return prio_t'($urandom_range(16)) - 16'sd8;
    endcase
  endfunction

  task automatic send_random(int enq_pct);
    op_t op;
    int  r;
    r = $urandom_range(99);
    if (r < enq_pct) op = OP_ENQ;
    else begin
      r = $urandom_range(9);
      op = (r < 6) ? OP_DEQ : (r < 8) ? OP_PEEK : OP_CHANGE;
    end
    send_word(op, pick_prio(), PAY_W'($urandom), pick_prio());
  endtask

  task automatic test_empty_errors();
    send_word(OP_DEQ, 16'sd0, '0, 16'sd0);
    send_word(OP_PEEK, PRIO_MAX, '1, PRIO_MIN);
    send_word(OP_CHANGE, PRIO_MIN, '1, PRIO_MAX);
  endtask

  task automatic test_extremes_and_saturation();
    send_word(OP_ENQ, PRIO_MAX, 32'hffff_ffff, 16'sd0);
    send_word(OP_ENQ, PRIO_MIN, 32'h0000_0000, 16'sd0);
    // a new word goes ahead of earlier ones of equal priority
    send_word(OP_ENQ, 16'sd5, 32'haaaa_5555, 16'sd0);
    send_word(OP_ENQ, 16'sd5, 32'h5555_aaaa, 16'sd0);
    send_word(OP_PEEK, 16'sd0, '0, 16'sd0);
    send_word(OP_CHANGE, 16'sd0, '0, PRIO_MAX);
    send_word(OP_CHANGE, 16'sd0, '0, PRIO_MIN);
    send_word(OP_PEEK, 16'sd0, '0, 16'sd0);
  endtask

  task automatic test_fill_to_full();
    repeat (CAPACITY - 4 + 1) send_word(OP_ENQ, pick_prio(), PAY_W'($urandom), 16'sd0);
    send_word(OP_DEQ, 16'sd0, '0, 16'sd0);
  endtask

  task automatic test_random_traffic();
    // alternate filling and draining phases so both full and empty are hit
    for (int ph = 0; ph < 8; ph++) begin
      repeat (50) send_random((ph % 2 == 0) ? 75 : 25);
    end
  endtask

  task automatic test_steady_stream();
    idling = 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      repeat (50) send_random((ph % 2 == 0) ? 70 : 30);
    end
    idling = 1'b1;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(negedge clk) begin
    out_chan.ready <= !idling || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    spq_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (awaited_results.size() == 0) begin
        $error("result word with nothing pending");
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_chan.status));
        check_field("out_priority", 32'(want.prio), 32'(out_chan.out_priority));
        check_field("out_payload", 32'(want.payload), 32'(out_chan.out_payload));
        check_field("entry_count", 32'(want.count), 32'(out_chan.entry_count));
        check_field("is_empty", 32'(want.empty), 32'(out_chan.is_empty));
        check_field("is_full", 32'(want.full), 32'(out_chan.is_full));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_n                 = 1'b0;
    idling                = 1'b1;
    in_chan.valid         = 1'b0;
    in_chan.op            = OP_ENQ;
    in_chan.item_priority = '0;
    in_chan.item_payload  = '0;
    in_chan.change_amount = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_errors();
    test_extremes_and_saturation();
    test_fill_to_full();
    test_random_traffic();
    test_steady_stream();

    in_chan.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
